>>> rtl/core/vertex_tilt_projection_core_macros.svh
// Assertion macros shared by the vertex tilt projection RTL.
// Every macro samples on aclk and is off while aresetn is low.
`ifndef VERTEX_TILT_PROJECTION_CORE_MACROS_SVH
`define VERTEX_TILT_PROJECTION_CORE_MACROS_SVH

// Same-cycle implication.
`define VTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/vtp_pkg.sv
// Shared types, constants and trig helpers for the vertex tilt projection core.
// No dependencies; used by vtp_coef, vtp_pipe and the top level.
`timescale 1ns / 1ps

package vtp_pkg;

    localparam int NUM_STAGES = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TILT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HSCALE = 2'd2;

    localparam logic [8:0]         TILT_RESET   = 9'd0;
    localparam logic signed [15:0] HSCALE_RESET = 16'sd256;

    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

    // round(sin(d deg) * 32768) for d = 0..90
    localparam logic [15:0] QSINE [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    // Q1.15 with +1.0 as 32768, so 17 bits signed
    typedef struct packed {
        logic signed [16:0] sa;
        logic signed [16:0] ca;
        logic signed [16:0] sb;
        logic signed [16:0] cb;
        logic signed [31:0] k1;   // sa * cb
        logic signed [15:0] hs;   // height scale, Q8.8
    } coef_t;

    // One subtract suffices for inputs below 720.
    function automatic logic [8:0] wrap_deg(input logic [9:0] deg);
        logic [9:0] d;
        d = (deg >= 10'd360) ? (deg - 10'd360) : deg;
        return d[8:0];
    endfunction

    function automatic logic signed [16:0] sine_q15(input logic [9:0] deg);
        logic [8:0]         d;
        logic [8:0]         ref_idx;
        logic               neg;
        logic signed [16:0] mag;
        d = wrap_deg(deg);
        if (d <= 9'd90) begin
            ref_idx = d;
            neg     = 1'b0;
        end else if (d <= 9'd180) begin
            ref_idx = 9'd180 - d;
            neg     = 1'b0;
        end else if (d <= 9'd270) begin
            ref_idx = d - 9'd180;
            neg     = 1'b1;
        end else begin
            ref_idx = 9'd360 - d;
            neg     = 1'b1;
        end
        mag = signed'({1'b0, QSINE[ref_idx[6:0]]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [16:0] cosine_q15(input logic [8:0] deg);
        return sine_q15({1'b0, wrap_deg({1'b0, deg})} + 10'd90);
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (v < 32'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/vtp_coef.sv
// Configuration registers and camera coefficient registers.
// Depends on vtp_pkg (coef_t, register indexes, trig helpers).
`timescale 1ns / 1ps

module vtp_coef (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output vtp_pkg::coef_t                    coef
);

    logic [8:0]         tilt_a_reg;
    logic [8:0]         tilt_b_reg;
    logic signed [15:0] hscale_reg;
    logic signed [16:0] sa_reg, ca_reg, sb_reg, cb_reg;
    logic signed [31:0] k1_reg;
    logic signed [33:0] k1_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_a_reg <= vtp_pkg::TILT_RESET;
            tilt_b_reg <= vtp_pkg::TILT_RESET;
            hscale_reg <= vtp_pkg::HSCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vtp_pkg::CFG_TILT_A: tilt_a_reg <= cfg_wdata[8:0];
                vtp_pkg::CFG_TILT_B: tilt_b_reg <= cfg_wdata[8:0];
                vtp_pkg::CFG_HSCALE: hscale_reg <= signed'(cfg_wdata);
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    assign k1_next = 34'(sa_reg) * 34'(cb_reg);

    // Trig values are registered from the tilt registers, the sa*cb product from the registered trig values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_reg <= '0;
            ca_reg <= 17'sd32768;
            sb_reg <= '0;
            cb_reg <= 17'sd32768;
            k1_reg <= '0;
        end else begin
            sa_reg <= vtp_pkg::sine_q15({1'b0, tilt_a_reg});
            ca_reg <= vtp_pkg::cosine_q15(tilt_a_reg);
            sb_reg <= vtp_pkg::sine_q15({1'b0, tilt_b_reg});
            cb_reg <= vtp_pkg::cosine_q15(tilt_b_reg);
            k1_reg <= k1_next[31:0];
        end
    end

    assign coef.sa = sa_reg;
    assign coef.ca = ca_reg;
    assign coef.sb = sb_reg;
    assign coef.cb = cb_reg;
    assign coef.k1 = k1_reg;
    assign coef.hs = hscale_reg;

endmodule

>>> rtl/core/vtp_pipe.sv
// Six-stage projection datapath with per-stage valid bits and a ready chain.
// Depends on vtp_pkg (coef_t, sat24, stage count) and the assertion macros.
`timescale 1ns / 1ps
`include "vertex_tilt_projection_core_macros.svh"

module vtp_pipe #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vtp_pkg::coef_t        coef,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    in_x,
    input  logic signed [15:0]    in_y,
    input  logic signed [15:0]    in_z,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [23:0]    out_sx,
    output logic signed [23:0]    out_sy,
    output logic signed [15:0]    out_z
);

    localparam int N      = vtp_pkg::NUM_STAGES;
    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_L = SCREEN_HEIGHT / 2;

    localparam logic signed [16:0] HW17    = 17'(HALF_W);
    localparam logic signed [16:0] HL17    = 17'(HALF_L);
    localparam logic signed [55:0] HW_TERM = 56'(HALF_W) <<< 30;
    localparam logic signed [49:0] HL_TERM = 50'(HALF_L) <<< 23;
    localparam logic signed [63:0] BIAS_X  = (64'sd1 <<< 38) - 64'sd1;
    localparam logic signed [49:0] BIAS_Y  = (50'sd1 <<< 23) - 50'sd1;

    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] ld;        // stage may load this cycle
    logic [N-1:0] move_out;  // stage hands its item on this cycle
    logic [N-1:0] upstream;  // valid bit feeding each stage

    // Ready chain: a stage loads when empty or when its item moves on.
    always_comb begin
        ld[N-1] = !valid_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--) begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
        upstream = {valid_reg[N-2:0], in_valid};
        for (int i = 0; i < N - 1; i++) begin
            move_out[i] = valid_reg[i] && ld[i+1];
        end
        move_out[N-1] = valid_reg[N-1] && out_ready;
        for (int i = 0; i < N; i++) begin
            valid_next[i] = ld[i] ? upstream[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ld[0] && aresetn;
    assign out_valid = valid_reg[N-1];

    // Stage 1: center on the screen
    logic signed [16:0] dx1_reg, dy1_reg;
    logic signed [15:0] z1_reg;

    // Stage 2: first products
    logic signed [33:0] cdx2_reg, sady2_reg, cbdy2_reg;
    logic signed [31:0] zhs2_reg;
    logic signed [15:0] z2_reg;

    // Stage 3: second products
    logic signed [63:0] zk3_reg;
    logic signed [50:0] sbsady3_reg;
    logic signed [48:0] zhssb3_reg;
    logic signed [33:0] cdx3_reg, cbdy3_reg;
    logic signed [15:0] z3_reg;

    // Stage 4: partial sums
    logic signed [55:0] axh4_reg;
    logic signed [49:0] ay4_reg;
    logic signed [63:0] zk4_reg;
    logic signed [15:0] z4_reg;

    // Stage 5: full accumulators, sx at 2^38, sy at 2^23
    logic signed [63:0] accx5_reg;
    logic signed [49:0] accy5_reg;
    logic signed [15:0] z5_reg;

    // Stage 6: output register
    logic signed [23:0] sx6_reg, sy6_reg;
    logic signed [15:0] z6_reg;

    logic signed [63:0] accx_biased;
    logic signed [49:0] accy_biased;
    logic signed [63:0] qx_full;
    logic signed [49:0] qy_full;

    always_comb begin
        accx_biased = accx5_reg + (accx5_reg[63] ? BIAS_X : 64'sd0);
        accy_biased = accy5_reg + (accy5_reg[49] ? BIAS_Y : 50'sd0);
        qx_full     = accx_biased >>> 38;
        qy_full     = accy_biased >>> 23;
    end

    always_ff @(posedge aclk) begin
        if (ld[0] && in_valid) begin
            dx1_reg <= 17'(in_x) - HW17;
            dy1_reg <= 17'(in_y) - HL17;
            z1_reg  <= in_z;
        end
        if (ld[1] && valid_reg[0]) begin
            cdx2_reg  <= 34'(coef.ca) * 34'(dx1_reg);
            sady2_reg <= 34'(coef.sa) * 34'(dy1_reg);
            cbdy2_reg <= 34'(coef.cb) * 34'(dy1_reg);
            zhs2_reg  <= 32'(z1_reg) * 32'(coef.hs);
            z2_reg    <= z1_reg;
        end
        if (ld[2] && valid_reg[1]) begin
            zk3_reg     <= 64'(zhs2_reg) * 64'(coef.k1);
            sbsady3_reg <= 51'(sady2_reg) * 51'(coef.sb);
            zhssb3_reg  <= 49'(zhs2_reg) * 49'(coef.sb);
            cdx3_reg    <= cdx2_reg;
            cbdy3_reg   <= cbdy2_reg;
            z3_reg      <= z2_reg;
        end
        if (ld[3] && valid_reg[2]) begin
            axh4_reg <= HW_TERM + (56'(cdx3_reg) <<< 15) - 56'(sbsady3_reg);
            ay4_reg  <= HL_TERM + (50'(cbdy3_reg) <<< 8) + 50'(zhssb3_reg);
            zk4_reg  <= zk3_reg;
            z4_reg   <= z3_reg;
        end
        if (ld[4] && valid_reg[3]) begin
            accx5_reg <= (64'(axh4_reg) <<< 8) + zk4_reg;
            accy5_reg <= ay4_reg;
            z5_reg    <= z4_reg;
        end
        if (ld[5] && valid_reg[4]) begin
            sx6_reg <= vtp_pkg::sat24(qx_full[31:0]);
            sy6_reg <= vtp_pkg::sat24(qy_full[31:0]);
            z6_reg  <= z5_reg;
        end
    end

    assign out_sx = sx6_reg;
    assign out_sy = sy6_reg;
    assign out_z  = z6_reg;

    logic [N-1:0] held;
    assign held = valid_reg & ~move_out;

    `VTP_ASSERT_NOW(a_full_when_stalled, !in_ready && aresetn, &valid_reg, "input stalled with a bubble in the pipe")
    `VTP_ASSERT_NEXT(a_held_items_stay, held != '0, (valid_reg & $past(held)) == $past(held), "stalled item lost")
    `VTP_ASSERT_NEXT(a_occupancy_up, in_valid && in_ready && !(out_valid && out_ready), $countones(valid_reg) == $past($countones(valid_reg)) + 1, "item count off after transfer in")

endmodule

>>> rtl/core/vertex_tilt_projection_core.sv
// A vertex passes through every stage register between its input transfer and m_tvalid.
// Throughput: one vertex per cycle; the six stage registers form a ready chain, so a
// stall on m_tready fills the bubbles first and s_tready drops only with all stages full.
// Reset (aresetn low, synchronous): empties every stage, sets both tilts to 0 and the
// height scale to 1.0; new tilts reach the datapath via the sin/cos and sa*cb registers.
`timescale 1ns / 1ps

module vertex_tilt_projection_core #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration: write-only, one register per transfer
    input  logic                              cfg_wr_en,
    input  logic [vtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vtp_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // vertex input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,  // map_x, map_y, map_height

    // projected result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata   // screen_x, screen_y, height_out
);

    vtp_pkg::coef_t     coef;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic signed [15:0] height_out;

    // Hold tilt and scale registers; derive sin/cos of both angles and sa*cb.
    vtp_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    // Stages: center, first products, second products, partial sums,
    // full sums, truncate toward zero and saturate into the output register.
    vtp_pipe #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (signed'(s_tdata[15:0])),
        .in_y      (signed'(s_tdata[31:16])),
        .in_z      (signed'(s_tdata[47:32])),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sx    (screen_x),
        .out_sy    (screen_y),
        .out_z     (height_out)
    );

    // Pack the result transfer, first field in the lowest bits.
    assign m_tdata = {height_out, screen_y, screen_x};

endmodule

>>> bench/tb_vertex_tilt_projection_core.sv
// Self-checking bench for vertex_tilt_projection_core: streams vertices through the core
// under several tilt/scale settings and flow-control mixes, checks each projection.
// Depends on vtp_pkg (register indexes, pipeline depth) and the core RTL only.
`timescale 1ns / 1ps

module tb_vertex_tilt_projection_core;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    // Quiet cycles around register writes, long enough to cover the pipeline and the coefficient registers.
    localparam int SETTLE_CYCLES = vtp_pkg::NUM_STAGES + 4;
    // Cycles without any transfer before the run is declared hung. A 62% stall rarely
    // holds anywhere near that long, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_SETTING = 50;
    localparam int SETTINGS_PER_PHASE = 5;

    // Index with no register behind it; the core must drop writes to it.
    localparam logic [vtp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [23:0] SCREEN_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SCREEN_MIN = 24'sh800000;

    // round(sin(d deg) * 32768), d = 0..90
    localparam int SINE_QUARTER [91] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    // Highest field first, so screen_x lands in the lowest bits of m_tdata.
    typedef struct packed {
        logic signed [15:0] height_out;
        logic signed [23:0] screen_y;
        logic signed [23:0] screen_x;
    } projection_t;

    // DUT signals; the inputs are all known from time zero
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vtp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata   = '0;   // map_x, map_y, map_height
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [63:0]                    m_tdata;          // screen_x, screen_y, height_out

    // Shadow copy of the core's registers
    logic [8:0]         tilt_a_shadow = vtp_pkg::TILT_RESET;
    logic [8:0]         tilt_b_shadow = vtp_pkg::TILT_RESET;
    logic signed [15:0] hscale_shadow = vtp_pkg::HSCALE_RESET;

    projection_t projections_due[$];
    projection_t seen_projection;
    projection_t due_projection;

    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int mismatch_count  = 0;
    int vertices_sent   = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    vertex_tilt_projection_core #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Projection predictor
    // ------------------------------------------------------------------

    // Q1.15 sine of a whole-degree angle; any non-negative angle wraps modulo 360.
    function automatic longint deg_sine(input int deg);
        int d;
        d = deg % 360;
        if (d <= 90)
            return SINE_QUARTER[d];
        else if (d <= 180)
            return SINE_QUARTER[180 - d];
        else if (d <= 270)
            return -SINE_QUARTER[d - 180];
        return -SINE_QUARTER[360 - d];
    endfunction

    function automatic logic signed [23:0] clamp_screen(input longint v);
        if (v > longint'(SCREEN_MAX))
            return SCREEN_MAX;
        if (v < longint'(SCREEN_MIN))
            return SCREEN_MIN;
        return v[23:0];
    endfunction

    // Sum every term exactly (sx at 2^38, sy at 2^23), then truncate toward zero once.
    function automatic projection_t project_vertex(input logic signed [15:0] map_x,
                                                   input logic signed [15:0] map_y,
                                                   input logic signed [15:0] map_height);
        longint half_w, half_l, sa, ca, sb, cb, dx, dy, z, hs, sum_x, sum_y;
        projection_t p;
        half_w = SCREEN_WIDTH / 2;
        half_l = SCREEN_HEIGHT / 2;
        sa     = deg_sine(int'(tilt_a_shadow));
        ca     = deg_sine(int'(tilt_a_shadow) % 360 + 90);
        sb     = deg_sine(int'(tilt_b_shadow));
        cb     = deg_sine(int'(tilt_b_shadow) % 360 + 90);
        dx     = longint'(map_x) - half_w;
        dy     = longint'(map_y) - half_l;
        z      = longint'(map_height);
        hs     = longint'(hscale_shadow);
        sum_x  = half_w * (64'sd1 <<< 38) + ca * dx * (64'sd1 <<< 23)
               + z * sa * hs * cb - sb * sa * dy * (64'sd1 <<< 8);
        sum_y  = half_l * (64'sd1 <<< 23) + cb * dy * (64'sd1 <<< 8) + z * sb * hs;
        p.screen_x   = clamp_screen(sum_x / (64'sd1 <<< 38));
        p.screen_y   = clamp_screen(sum_y / (64'sd1 <<< 23));
        p.height_out = map_height;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stall generator
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_projection = m_tdata;
            results_checked++;
            if (projections_due.size() == 0) begin
                $error("unexpected result: screen_x %0d screen_y %0d height_out %0d",
                       seen_projection.screen_x, seen_projection.screen_y,
                       seen_projection.height_out);
                mismatch_count++;
            end else begin
                due_projection = projections_due.pop_front();
                if (seen_projection.screen_x !== due_projection.screen_x) begin
                    $error("screen_x: expected %0d, got %0d",
                           due_projection.screen_x, seen_projection.screen_x);
                    mismatch_count++;
                end
                if (seen_projection.screen_y !== due_projection.screen_y) begin
                    $error("screen_y: expected %0d, got %0d",
                           due_projection.screen_y, seen_projection.screen_y);
                    mismatch_count++;
                end
                if (seen_projection.height_out !== due_projection.height_out) begin
                    $error("height_out: expected %0d, got %0d",
                           due_projection.height_out, seen_projection.height_out);
                    mismatch_count++;
                end
            end
        end
        // Decide the stall for the next cycle.
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: end the run when neither side has moved a transfer for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, projections_due.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Present one vertex, hold it until the core takes it, then log the expected projection.
    // Returns at the accepting edge with s_tvalid still high.
    task automatic send_vertex(input logic signed [15:0] map_x,
                               input logic signed [15:0] map_y,
                               input logic signed [15:0] map_height);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {map_height, map_y, map_x};
        do
            @(posedge aclk);
        while (!s_tready);
        projections_due.push_back(project_vertex(map_x, map_y, map_height));
        vertices_sent++;
    endtask

    // Drop valid and hold until every outstanding projection has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (projections_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input logic [vtp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [vtp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        unique case (idx)
            vtp_pkg::CFG_TILT_A: tilt_a_shadow = data[8:0];
            vtp_pkg::CFG_TILT_B: tilt_b_shadow = data[8:0];
            vtp_pkg::CFG_HSCALE: hscale_shadow = data;
            default: ;  // unmapped index, nothing changes
        endcase
    endtask

    // Reprogram all registers with the core empty, then let the new tilts settle.
    task automatic program_registers(input logic [vtp_pkg::CFG_DATA_W-1:0] tilt_a,
                                     input logic [vtp_pkg::CFG_DATA_W-1:0] tilt_b,
                                     input logic [vtp_pkg::CFG_DATA_W-1:0] hscale);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_register(vtp_pkg::CFG_TILT_A, tilt_a);
        write_register(vtp_pkg::CFG_TILT_B, tilt_b);
        write_register(vtp_pkg::CFG_HSCALE, hscale);
        if ($urandom_range(3) == 0)
            write_register(CFG_UNUSED, 16'($urandom()));
        cfg_wr_en <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        settings_used++;
    endtask

    // Mostly full-range fields, some near screen center, a few pinned at the extremes.
    function automatic logic signed [15:0] pick_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return 16'($urandom());
        if (sel < 85)
            return 16'(512 + $urandom_range(0, 2047) - 1024);
        return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
    endfunction

    // Angles cover the wrap region 360..511 and the quadrant edges often.
    function automatic logic [vtp_pkg::CFG_DATA_W-1:0] pick_tilt();
        int sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return 16'($urandom_range(0, 5) * 90);
        if (sel < 5)
            return 16'($urandom_range(360, 511));
        if (sel < 6)
            return 16'($urandom());  // upper bits must be ignored
        return 16'($urandom_range(0, 359));
    endfunction

    function automatic logic [vtp_pkg::CFG_DATA_W-1:0] pick_hscale();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return 16'($urandom());
        if (sel < 8)
            return 16'($urandom_range(0, 1024) - 512);
        return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Reset values: no tilt, unit height scale, fields at zero, at screen center, at -1 and at their extremes.
    task automatic test_reset_defaults();
        send_vertex(16'sd0, 16'sd0, 16'sd0);
        send_vertex(16'sd512, 16'sd512, 16'sd100);
        send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(-16'sd1, -16'sd1, -16'sd1);
        send_vertex(16'sh7FFF, 16'sh8000, 16'sd1);
    endtask

    // Quadrant angles, the last valid degree, wrapped angles, scale extremes and zero scale,
    // each driven with the extreme vertices that push the sums hardest plus one random vertex.
    task automatic test_angle_corners();
        logic [vtp_pkg::CFG_DATA_W-1:0] corner_a  [4] = '{16'd90,   16'd270,  16'd359,  16'd511};
        logic [vtp_pkg::CFG_DATA_W-1:0] corner_b  [4] = '{16'd0,    16'd180,  16'd90,   16'd360};
        logic [vtp_pkg::CFG_DATA_W-1:0] corner_hs [4] = '{16'h8000, 16'h7FFF, 16'h8000, 16'h0000};
        for (int i = 0; i < 4; i++) begin
            program_registers(corner_a[i], corner_b[i], corner_hs[i]);
            send_vertex(16'sh7FFF, 16'sh8000, 16'sh8000);
            send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF);
            send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
            send_vertex(pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    // Random stream under one idling mix; registers change between batches.
    // With hold_off set, the sender also stops now and then until the core is empty.
    task automatic test_random_stream(input int src_pct, input int sink_pct,
                                      input bit hold_off);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            program_registers(pick_tilt(), pick_tilt(), pick_hscale());
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                send_vertex(pick_coord(), pick_coord(), pick_coord());
                if (hold_off && $urandom_range(19) == 0)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_angle_corners();

        test_random_stream(0, 0, 1'b0);
        test_random_stream(62, 0, 1'b1);
        test_random_stream(0, 62, 1'b0);
        test_random_stream(27, 27, 1'b1);

        drain_results();
        // Catch any stray result the core might still emit.
        repeat (vtp_pkg::NUM_STAGES * 4) @(posedge aclk);

        $display("Run covered %0d vertices and %0d results over %0d register settings,",
                 vertices_sent, results_checked, settings_used);
        $display("with free flow, sender gaps, receiver stalls and both combined.");
        if (mismatch_count == 0 && projections_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, projections_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> vertex_tilt_projection_core.f
+incdir+rtl/core
rtl/core/vtp_pkg.sv
rtl/core/vtp_coef.sv
rtl/core/vtp_pipe.sv
rtl/core/vertex_tilt_projection_core.sv
bench/tb_vertex_tilt_projection_core.sv
